[design/tlv_string_list_validator_unit_macros.svh]
// assertion macros shared by the tlv string list validator rtl
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef TLV_STRING_LIST_VALIDATOR_UNIT_MACROS_SVH
`define TLV_STRING_LIST_VALIDATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLVSV_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tlvsv assertion failed");

// next-cycle implication, disabled during reset
`define TLVSV_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tlvsv assertion failed");

`endif

[design/tlvsv_pkg.sv]
// types and constants for the tlv string list validator
// no dependencies
`default_nettype none

package tlvsv_pkg;

  localparam int AreaLenW          = 11;
  localparam int ByteW             = 8;
  localparam int CountW            = 9;
  localparam int StatusW           = 3;
  localparam int CfgIdxW           = 2;
  localparam int MaxAreaBytesDflt  = 1024;

  // verdict codes
  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StBadType   = 3'd1;
  localparam logic [StatusW-1:0] StOrder     = 3'd2;
  localparam logic [StatusW-1:0] StTooLong   = 3'd3;
  localparam logic [StatusW-1:0] StBadString = 3'd4;
  localparam logic [StatusW-1:0] StNoTerm    = 3'd5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLimitOne   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLimitTwo   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLimitThree = 2'd2;

  localparam logic [ByteW-1:0] LimitOneRst   = 8'd12;
  localparam logic [ByteW-1:0] LimitTwoRst   = 8'd16;
  localparam logic [ByteW-1:0] LimitThreeRst = 8'd64;

  typedef struct packed {
    logic [ByteW-1:0]    data_byte;
    logic                start_of_area;
    logic [AreaLenW-1:0] area_length;
    logic                list_kind;
  } in_word_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic [ByteW-1:0] one;
    logic [ByteW-1:0] two;
    logic [ByteW-1:0] three;
  } limits_t;

  typedef struct packed {
    logic      idle;
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

`default_nettype wire

[design/tlvsv_parser.sv]
// byte-wise tlv list parser: state registers and next-state logic
// depends on tlvsv_pkg
`default_nettype none

module tlvsv_parser #(
  parameter int MAX_AREA_BYTES = tlvsv_pkg::MaxAreaBytesDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  tlvsv_pkg::in_word_t in_i,
  input  tlvsv_pkg::limits_t  lim_i,
  output tlvsv_pkg::res_t     res_o
);
  import tlvsv_pkg::*;

  localparam int RemW = $clog2(MAX_AREA_BYTES + 1);
  localparam int CmpW = ((RemW > AreaLenW) ? RemW : AreaLenW) + 1;

  typedef enum logic [1:0] {
    PhType  = 2'd0,
    PhLen   = 2'd1,
    PhValue = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [1:0]        cur_q, cur_d;
  logic [1:0]        exp_q, exp_d;
  logic [ByteW-1:0]  vlen_q, vlen_d;
  logic [ByteW-1:0]  vpos_q, vpos_d;
  logic [CountW-1:0] items_q, items_d;
  logic              kind_q, kind_d;
  logic              done_q, done_d;

  logic [CmpW-1:0]   len_ext, sat_len, need, rem_ext, rem_left;
  logic [ByteW:0]    pos_next;
  logic [ByteW-1:0]  lim;
  logic [ByteW-1:0]  b;
  logic              fin;
  logic [StatusW-1:0] st;

  function automatic logic [ByteW-1:0] limit_for(logic [1:0] t, limits_t l);
    logic [ByteW-1:0] r;
    r = '0;
    case (t)
      2'd1:    r = l.one;
      2'd2:    r = l.two;
      2'd3:    r = l.three;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign b       = in_i.data_byte;
  assign len_ext = CmpW'(in_i.area_length);
  assign sat_len = (len_ext > CmpW'(MAX_AREA_BYTES)) ? CmpW'(MAX_AREA_BYTES) : len_ext;

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    cur_d   = cur_q;
    exp_d   = exp_q;
    vlen_d  = vlen_q;
    vpos_d  = vpos_q;
    items_d = items_q;
    kind_d  = kind_q;
    done_d  = done_q;
    fin     = 1'b0;
    st      = StOk;

    // a start byte opens a fresh area before the byte itself is parsed
    if (in_i.start_of_area) begin
      rem_d   = RemW'(sat_len);
      kind_d  = in_i.list_kind;
      exp_d   = in_i.list_kind ? 2'd1 : 2'd0;
      items_d = '0;
      done_d  = 1'b0;
      phase_d = PhType;
      cur_d   = '0;
      vlen_d  = '0;
      vpos_d  = '0;
    end

    lim      = limit_for(cur_d, lim_i);
    need     = CmpW'(b) + CmpW'(2);
    rem_ext  = CmpW'(rem_d);
    rem_left = rem_ext - (CmpW'(vlen_d) + CmpW'(2));
    pos_next = {1'b0, vpos_d} + 1'b1;

    if (!done_d) begin
      unique case (phase_d)
        PhLen: begin
          vlen_d = b;
          vpos_d = '0;
          if (b > lim || need > rem_ext) begin
            fin = 1'b1;
            st  = StTooLong;
          end else if (cur_d == 2'd0) begin
            fin = 1'b1;
            st  = StOk;
          end else if (b == '0) begin
            fin = 1'b1;
            st  = StBadString;
          end else begin
            phase_d = PhValue;
          end
        end
        PhValue: begin
          if (pos_next < {1'b0, vlen_d}) begin
            if (b == '0) begin
              fin = 1'b1;
              st  = StBadString;
            end else begin
              vpos_d = pos_next[ByteW-1:0];
            end
          end else if (b != '0) begin
            fin = 1'b1;
            st  = StBadString;
          end else begin
            if (items_d != '1) items_d = items_d + 1'b1;
            if (kind_d) exp_d = 2'd1;
            else        exp_d = (cur_d == 2'd3) ? 2'd1 : cur_d + 2'd1;
            rem_d   = RemW'(rem_left);
            phase_d = PhType;
            if (rem_left == '0) begin
              fin = 1'b1;
              st  = StNoTerm;
            end
          end
        end
        default: begin
          // type byte, also taken for the unused phase code
          if (b > 8'd3) begin
            fin = 1'b1;
            st  = StBadType;
          end else if (exp_d != 2'd0 && b != '0 && b != {6'd0, exp_d}) begin
            fin = 1'b1;
            st  = StOrder;
          end else begin
            cur_d   = b[1:0];
            phase_d = PhLen;
          end
        end
      endcase
      if (fin) begin
        done_d  = 1'b1;
        phase_d = PhType;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhType;
      rem_q   <= '0;
      cur_q   <= '0;
      exp_q   <= '0;
      vlen_q  <= '0;
      vpos_q  <= '0;
      items_q <= '0;
      kind_q  <= 1'b0;
      done_q  <= 1'b1;
    end else if (fire_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      cur_q   <= cur_d;
      exp_q   <= exp_d;
      vlen_q  <= vlen_d;
      vpos_q  <= vpos_d;
      items_q <= items_d;
      kind_q  <= kind_d;
      done_q  <= done_d;
    end
  end

  assign res_o.idle             = done_q;
  assign res_o.valid            = fin;
  assign res_o.word.status      = st;
  assign res_o.word.entry_count = items_d;

endmodule

`default_nettype wire

[design/tlv_string_list_validator_unit.sv]
// Validates the TLV area of a packet, one byte per word on the input
// channel. A word with start_of_area opens an area (area_length and
// list_kind are taken from that word, length saturated to MAX_AREA_BYTES);
// each item is a type byte, a length byte and a zero-terminated string.
// At most one verdict word (status, entry_count) is produced per area, on the
// cycle after the byte that decides it; bytes outside an area give none.
// Throughput is one byte per clock while in_ready_o is high: each byte passes
// through a few compares and one small subtract between the parser state and
// the result register. The result register decouples the two sides, so input
// ready only drops while a verdict sits unaccepted and the output is stalled.
// Limits are written through the cfg port (index 0..2); the user must write
// them only while no area is in progress, which the block does not enforce.
// depends on tlvsv_pkg, tlvsv_parser and the assertion macro header
`default_nettype none

`include "tlv_string_list_validator_unit_macros.svh"

module tlv_string_list_validator_unit #(
  parameter int MAX_AREA_BYTES = tlvsv_pkg::MaxAreaBytesDflt
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte words in
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tlvsv_pkg::in_word_t               in_data_i,
  // verdict words out
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tlvsv_pkg::out_word_t              out_data_o,
  // limit registers
  input  logic                              cfg_we_i,
  input  logic [tlvsv_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tlvsv_pkg::ByteW-1:0]       cfg_data_i
);
  import tlvsv_pkg::*;

  limits_t   lim_q;
  res_t      res;
  logic      fire;
  logic      out_valid_q;
  out_word_t out_word_q;

  // per-type value length limits, type 0 is fixed at zero in the parser
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.one   <= LimitOneRst;
      lim_q.two   <= LimitTwoRst;
      lim_q.three <= LimitThreeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLimitOne:   lim_q.one   <= cfg_data_i;
        RegLimitTwo:   lim_q.two   <= cfg_data_i;
        RegLimitThree: lim_q.three <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // take a byte whenever the result slot is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  tlvsv_parser #(
    .MAX_AREA_BYTES(MAX_AREA_BYTES)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .in_i   (in_data_i),
    .lim_i  (lim_q),
    .res_o  (res)
  );

  // result register, valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register, payload
  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_word_q <= res.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // running out of bytes can only follow a completed item
  `TLVSV_ASSERT_NOW(a_noterm_counts,
    out_valid_o && out_data_o.status == StNoTerm,
    out_data_o.entry_count != '0)
  // a start byte with an illegal type is rejected right away
  `TLVSV_ASSERT_NEXT(a_bad_type_first,
    fire && in_data_i.start_of_area && in_data_i.data_byte > 8'd3,
    out_valid_o && out_data_o.status == StBadType)
  // bytes outside an area never produce a verdict
  `TLVSV_ASSERT_NEXT(a_idle_silent, fire && res.idle && !in_data_i.start_of_area, !out_valid_o)

endmodule

`default_nettype wire
